/* rtl/core/dlr_pkg.sv */
// Shared types and constants for the dense layer ReLU unit.
// No dependencies; every other file of the block uses this package.
package dlr_pkg;

   localparam int LANES      = 8;
   localparam int LANE_IDX_W = 3;
   localparam int DATA_W     = 16;
   localparam int CNT_W      = 4;
   localparam int FRAC_W     = 4;
   localparam logic [FRAC_W-1:0] FRAC_RESET = 4'd8;
   localparam int ACC_W      = 48;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int DOT_W      = PROD_W + LANE_IDX_W;
   localparam int BIAS_SC_W  = DATA_W + 15;
   localparam int VALUE_W    = 15;
   localparam int INDEX_W    = 12;

   localparam int CMD_DEPTH  = 4;
   localparam int CMD_PTR_W  = 2;
   localparam int CMD_CNT_W  = 3;

   // Item kind codes carried in req_type.
   localparam logic REQ_ACTIVATION = 1'b0;
   localparam logic REQ_WEIGHT     = 1'b1;

   typedef struct packed {
      logic                     req_type;
      logic signed [DATA_W-1:0] lane_data_0;
      logic signed [DATA_W-1:0] lane_data_1;
      logic signed [DATA_W-1:0] lane_data_2;
      logic signed [DATA_W-1:0] lane_data_3;
      logic signed [DATA_W-1:0] lane_data_4;
      logic signed [DATA_W-1:0] lane_data_5;
      logic signed [DATA_W-1:0] lane_data_6;
      logic signed [DATA_W-1:0] lane_data_7;
      logic [CNT_W-1:0]         lanes_valid;
      logic signed [DATA_W-1:0] neuron_bias;
      logic                     last_chunk;
   } req_payload_type;

   typedef struct packed {
      logic [VALUE_W-1:0] neuron_value;
      logic               saturated;
      logic [INDEX_W-1:0] neuron_index;
   } rsp_payload_type;

   typedef struct packed {
      logic                          is_weight;
      logic                          last;
      logic [CNT_W-1:0]              count;
      logic [LANES-1:0][DATA_W-1:0]  lane;
      logic [DATA_W-1:0]             bias;
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic is_weight;
      logic last;
   } stage_ctrl_type;

endpackage

/* rtl/core/dlr_ifs.sv */
// Valid/ready channel interfaces for the request and response sides.
// Depends on dlr_pkg for the payload types.
interface dlr_req_if;
   logic                     valid;
   logic                     ready;
   dlr_pkg::req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface dlr_rsp_if;
   logic                     valid;
   logic                     ready;
   dlr_pkg::rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/dense_layer_relu_unit.sv */
// Top level of the fully connected layer with ReLU.
// Depends on dlr_pkg, dlr_ifs, dlr_front, dlr_cmd_fifo and dlr_back.
//
// Usage:
//   req_if carries one transaction per item: an activation chunk (req_type 0)
//   is written into the activation store, a weight chunk (req_type 1) is
//   multiplied against the stored activations and summed into the
//   accumulator. A weight chunk with last_chunk set adds the bias, applies
//   ReLU, scales by frac_bits, saturates and produces one rsp_if transaction.
//   csr_wr_en/csr_wr_data write frac_bits; write it only while the block is
//   idle.
// Throughput: one request transaction per cycle, every chunk type, while the command queue is not full.
// Path: an accepted last weight chunk passes the command queue, the store
//   read, multiply, adder tree, accumulate and the output register before it
//   shows up on rsp_if.
// Reset: positions, accumulator and neuron counter clear, frac_bits becomes
//   8; the activation store keeps no reset value and needs no clearing pass.
// Stall: while rsp_if.ready is low and a result is held, the back pipeline
//   holds and the four-entry command queue keeps taking requests until full.
module dense_layer_relu_unit #(
   parameter int MAX_INPUTS = 2048
) (
   input  logic                         clock,
   input  logic                         reset,
   dlr_req_if.sink                      req_if,
   dlr_rsp_if.source                    rsp_if,
   input  logic                         csr_wr_en,
   input  logic [dlr_pkg::FRAC_W-1:0]   csr_wr_data
);
   import dlr_pkg::*;

   logic              front_valid;
   logic              front_ready;
   cmd_type           front_cmd;
   logic              back_valid;
   logic              back_ready;
   cmd_type           back_cmd;
   logic [FRAC_W-1:0] frac_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frac_ff <= FRAC_RESET;
      end else if (csr_wr_en) begin
         frac_ff <= csr_wr_data;
      end
   end

   dlr_front u_front (
      .req_if    (req_if),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready),
      .cmd       (front_cmd)
   );

   dlr_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_cmd    (front_cmd),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_cmd   (back_cmd)
   );

   dlr_back #(
      .MAX_INPUTS (MAX_INPUTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (back_valid),
      .cmd_ready (back_ready),
      .cmd       (back_cmd),
      .frac_bits (frac_ff),
      .rsp_if    (rsp_if)
   );

endmodule

/* rtl/core/dlr_front.sv */
// Front end: accepts request transactions and turns them into commands.
// Depends on dlr_pkg and dlr_req_if.
module dlr_front (
   dlr_req_if.sink          req_if,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output dlr_pkg::cmd_type cmd
);
   import dlr_pkg::*;

   assign cmd_valid    = req_if.valid;
   assign req_if.ready = cmd_ready;

   always_comb begin
      cmd.is_weight = (req_if.data.req_type == REQ_WEIGHT);
      cmd.last      = req_if.data.last_chunk;
      // Lane counts above LANES use every lane.
      if (req_if.data.lanes_valid > CNT_W'(LANES)) begin
         cmd.count = CNT_W'(LANES);
      end else begin
         cmd.count = req_if.data.lanes_valid;
      end
      cmd.lane[0] = req_if.data.lane_data_0;
      cmd.lane[1] = req_if.data.lane_data_1;
      cmd.lane[2] = req_if.data.lane_data_2;
      cmd.lane[3] = req_if.data.lane_data_3;
      cmd.lane[4] = req_if.data.lane_data_4;
      cmd.lane[5] = req_if.data.lane_data_5;
      cmd.lane[6] = req_if.data.lane_data_6;
      cmd.lane[7] = req_if.data.lane_data_7;
      cmd.bias    = req_if.data.neuron_bias;
   end

endmodule

/* rtl/core/dlr_cmd_fifo.sv */
// Short command queue between the front end and the back end.
// Depends on dlr_pkg.
module dlr_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  dlr_pkg::cmd_type in_cmd,
   output logic             out_valid,
   input  logic             out_ready,
   output dlr_pkg::cmd_type out_cmd
);
   import dlr_pkg::*;

   cmd_type                entry_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]   count_ff, count_in;
   logic                   push;
   logic                   pop;

   assign in_ready  = (count_ff != CMD_CNT_W'(CMD_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

/* rtl/core/dlr_back.sv */
// Back end: banked activation store, multiply, adder tree, accumulator and
// ReLU/saturate output register. Depends on dlr_pkg and dlr_rsp_if.
module dlr_back #(
   parameter int MAX_INPUTS = 2048
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   output logic                         cmd_ready,
   input  dlr_pkg::cmd_type             cmd,
   input  logic [dlr_pkg::FRAC_W-1:0]   frac_bits,
   dlr_rsp_if.source                    rsp_if
);
   import dlr_pkg::*;

   localparam int POS_W = $clog2(MAX_INPUTS + 1);
   localparam int SUM_W = POS_W + 1;
   localparam int ROWS  = (MAX_INPUTS + LANES - 1) / LANES;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic adv;
   logic take;

   // Issue stage state.
   logic [POS_W-1:0] wr_pos_ff, wr_pos_in;
   logic [POS_W-1:0] rd_pos_ff, rd_pos_in;
   logic [POS_W-1:0] pos;
   logic [SUM_W-1:0] pos_next;
   logic [POS_W-1:0] pos_clamped;

   logic [LANES-1:0]  hit;
   logic [ROW_W-1:0]  row      [LANES];
   logic [DATA_W-1:0] lane_sel [LANES];
   logic [DATA_W-1:0] rd_ff    [LANES];

   stage_ctrl_type s1_ctrl_ff, s2_ctrl_ff, s3_ctrl_ff;
   logic [LANES-1:0]         s1_mask_ff;
   logic [DATA_W-1:0]        s1_w_ff [LANES];
   logic signed [DATA_W-1:0] s1_bias_ff, s2_bias_ff;

   logic signed [PROD_W-1:0] prod_in [LANES];
   logic signed [PROD_W-1:0] s2_prod_ff [LANES];

   logic signed [PROD_W:0]    tree_l1 [4];
   logic signed [PROD_W+1:0]  tree_l2 [2];
   logic signed [DOT_W-1:0]   dot_in;
   logic signed [DOT_W-1:0]   s3_dot_ff;
   logic signed [BIAS_SC_W-1:0] bias_sc_in, s3_bias_sc_ff;

   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [INDEX_W-1:0]      cnt_ff, cnt_in;
   logic signed [ACC_W-1:0] partial;
   logic signed [ACC_W-1:0] total_in, s4_total_ff;
   logic [INDEX_W-1:0]      s4_index_ff;
   logic                    s4_valid_ff, s4_valid_in;

   logic                    rsp_valid_ff;
   rsp_payload_type         rsp_data_ff, rsp_data_in;
   logic                    positive;
   logic [ACC_W-1:0]        shifted;

   // The whole back pipeline moves together; it holds only while a finished
   // result waits in the output register.
   assign adv       = !rsp_valid_ff || rsp_if.ready;
   assign cmd_ready = adv;
   assign take      = cmd_valid && adv;

   // ---------------- Issue stage: positions and bank access ----------------
   assign pos = cmd.is_weight ? rd_pos_ff : wr_pos_ff;

   always_comb begin
      pos_next = SUM_W'(pos) + SUM_W'(cmd.count);
      if (pos_next > SUM_W'(MAX_INPUTS)) begin
         pos_clamped = POS_W'(MAX_INPUTS);
      end else begin
         pos_clamped = pos_next[POS_W-1:0];
      end
      wr_pos_in = wr_pos_ff;
      rd_pos_in = rd_pos_ff;
      if (take) begin
         if (cmd.is_weight) begin
            rd_pos_in = cmd.last ? '0 : pos_clamped;
         end else begin
            wr_pos_in = cmd.last ? '0 : pos_clamped;
            rd_pos_in = '0;
         end
      end
   end

   // Address a maps to bank a mod LANES, row a / LANES, so any run of up to
   // LANES consecutive addresses touches each bank at most once.
   for (genvar b = 0; b < LANES; b++) begin : g_bank
      logic [LANE_IDX_W-1:0] k;
      logic [SUM_W-1:0]      addr;
      logic [DATA_W-1:0]     mem [ROWS];

      assign k           = LANE_IDX_W'(b) - pos[LANE_IDX_W-1:0];
      assign addr        = SUM_W'(pos) + SUM_W'(k);
      assign hit[b]      = (CNT_W'(k) < cmd.count) && (addr < SUM_W'(MAX_INPUTS));
      assign row[b]      = ROW_W'(addr >> LANE_IDX_W);
      assign lane_sel[b] = cmd.lane[k];

      always_ff @(posedge clock) begin
         if (take && !cmd.is_weight && hit[b]) begin
            mem[row[b]] <= lane_sel[b];
         end
         if (adv) begin
            rd_ff[b] <= mem[row[b]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff  <= '0;
         rd_pos_ff  <= '0;
         s1_ctrl_ff <= '0;
      end else begin
         wr_pos_ff <= wr_pos_in;
         rd_pos_ff <= rd_pos_in;
         if (adv) begin
            s1_ctrl_ff.valid     <= take;
            s1_ctrl_ff.is_weight <= cmd.is_weight;
            s1_ctrl_ff.last      <= cmd.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_mask_ff <= hit;
         s1_bias_ff <= cmd.bias;
         for (int i = 0; i < LANES; i++) begin
            s1_w_ff[i] <= lane_sel[i];
         end
      end
   end

   // ---------------- Multiply stage ----------------
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         if (s1_ctrl_ff.is_weight && s1_mask_ff[i]) begin
            prod_in[i] = $signed(rd_ff[i]) * $signed(s1_w_ff[i]);
         end else begin
            prod_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctrl_ff <= '0;
      end else if (adv) begin
         s2_ctrl_ff <= s1_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_bias_ff <= s1_bias_ff;
         for (int i = 0; i < LANES; i++) begin
            s2_prod_ff[i] <= prod_in[i];
         end
      end
   end

   // ---------------- Adder tree stage ----------------
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         tree_l1[i] = (PROD_W + 1)'(s2_prod_ff[2 * i]) + (PROD_W + 1)'(s2_prod_ff[2 * i + 1]);
      end
      for (int i = 0; i < 2; i++) begin
         tree_l2[i] = (PROD_W + 2)'(tree_l1[2 * i]) + (PROD_W + 2)'(tree_l1[2 * i + 1]);
      end
      dot_in     = DOT_W'(tree_l2[0]) + DOT_W'(tree_l2[1]);
      bias_sc_in = BIAS_SC_W'(s2_bias_ff) <<< frac_bits;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctrl_ff <= '0;
      end else if (adv) begin
         s3_ctrl_ff <= s2_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_dot_ff     <= dot_in;
         s3_bias_sc_ff <= bias_sc_in;
      end
   end

   // ---------------- Accumulate stage ----------------
   always_comb begin
      partial     = acc_ff + ACC_W'(s3_dot_ff);
      total_in    = partial + ACC_W'(s3_bias_sc_ff);
      acc_in      = acc_ff;
      cnt_in      = cnt_ff;
      s4_valid_in = 1'b0;
      if (s3_ctrl_ff.valid) begin
         if (!s3_ctrl_ff.is_weight) begin
            // An activation transaction starts a new layer pass.
            acc_in = '0;
            cnt_in = '0;
         end else if (s3_ctrl_ff.last) begin
            acc_in      = '0;
            cnt_in      = cnt_ff + 1'b1;
            s4_valid_in = 1'b1;
         end else begin
            acc_in = partial;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= '0;
         cnt_ff      <= '0;
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         acc_ff      <= acc_in;
         cnt_ff      <= cnt_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_total_ff <= total_in;
         s4_index_ff <= cnt_ff;
      end
   end

   // ---------------- ReLU, scale and saturate into the output register ----
   always_comb begin
      positive = !s4_total_ff[ACC_W-1] && (s4_total_ff != '0);
      shifted  = $unsigned(s4_total_ff) >> frac_bits;
      rsp_data_in.neuron_index = s4_index_ff;
      rsp_data_in.saturated    = positive && (shifted[ACC_W-1:VALUE_W] != '0);
      if (!positive) begin
         rsp_data_in.neuron_value = '0;
      end else if (rsp_data_in.saturated) begin
         rsp_data_in.neuron_value = '1;
      end else begin
         rsp_data_in.neuron_value = shifted[VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

endmodule
